[src/lcct_pkg.sv]
// Shared types and constants for the loss-of-control chute trigger.
// No dependencies; imported by every module of the block.
`default_nettype none
package lcct_pkg;

  localparam int CNT_W  = 16;
  localparam int ANG_W  = 15;
  localparam int MALT_W = 15;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_CRASH_EN  = 2'd0;
  localparam logic [1:0] REG_MIN_ALT   = 2'd1;
  localparam logic [1:0] REG_TRIG      = 2'd2;
  localparam logic [1:0] REG_ANG_LIMIT = 2'd3;

  localparam logic              RST_CRASH_EN  = 1'b1;
  localparam logic [MALT_W-1:0] RST_MIN_ALT   = MALT_W'(10);
  localparam logic [CNT_W-1:0]  RST_TRIG      = CNT_W'(400);
  localparam logic [ANG_W-1:0]  RST_ANG_LIMIT = ANG_W'(3000);

  typedef struct packed {
    logic              crash_check_enable;
    logic [MALT_W-1:0] min_altitude_m;
    logic [CNT_W-1:0]  trigger_ticks;
    logic [ANG_W-1:0]  angle_limit_cdeg;
  } cfg_t;

  typedef struct packed {
    logic chute_enabled;
    logic standby;
    logic armed;
    logic release_started;
    logic acro_or_flip;
    logic landed;
  } flags_t;

  typedef struct packed {
    logic             fire_release;
    logic             disarm_request;
    logic             flying;
    logic [CNT_W-1:0] loss_count;
  } res_t;

endpackage
`default_nettype wire

[src/lcct_cfg.sv]
// APB-style register file for the trigger settings.
// Depends on lcct_pkg for the register layout and reset values.
`default_nettype none
module lcct_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lcct_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [lcct_pkg::PDATA_W-1:0]  pwdata,
  output logic      [lcct_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output lcct_pkg::cfg_t                     cfg
);
  import lcct_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crash_check_enable <= RST_CRASH_EN;
      cfg.min_altitude_m     <= RST_MIN_ALT;
      cfg.trigger_ticks      <= RST_TRIG;
      cfg.angle_limit_cdeg   <= RST_ANG_LIMIT;
    end else if (wr) begin
      unique case (idx)
        REG_CRASH_EN:  cfg.crash_check_enable <= pwdata[0];
        REG_MIN_ALT:   cfg.min_altitude_m     <= pwdata[MALT_W-1:0];
        REG_TRIG:      cfg.trigger_ticks      <= pwdata[CNT_W-1:0];
        REG_ANG_LIMIT: cfg.angle_limit_cdeg   <= pwdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CRASH_EN:  prdata = PDATA_W'(cfg.crash_check_enable);
      REG_MIN_ALT:   prdata = PDATA_W'(cfg.min_altitude_m);
      REG_TRIG:      prdata = PDATA_W'(cfg.trigger_ticks);
      REG_ANG_LIMIT: prdata = PDATA_W'(cfg.angle_limit_cdeg);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[src/lcct_step.sv]
// Per-tick decision logic plus the loss counter and baro latch.
// Depends on lcct_pkg for the settings, flag and result types.
`default_nettype none
module lcct_step #(
  parameter int ALT_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         update,
  input  wire lcct_pkg::cfg_t               cfg,
  input  wire lcct_pkg::flags_t             flags,
  input  wire logic signed [ALT_BITS-1:0]   altitude_cm,
  input  wire logic [lcct_pkg::ANG_W-1:0]   angle_error_cdeg,
  input  wire logic signed [ALT_BITS-1:0]   baro_altitude_cm,
  output lcct_pkg::res_t                    res
);
  import lcct_pkg::*;

  // metres * 100 fits in 22 bits; one sign bit on top of the wider operand
  localparam int MUL_W = 22;
  localparam int CMP_W = ((ALT_BITS > MUL_W) ? ALT_BITS : MUL_W) + 1;

  logic [CNT_W-1:0]           loss_count, loss_count_next;
  logic signed [ALT_BITS-1:0] baro_start_cm, baro_start_cm_next;

  logic [MUL_W-1:0]        m100;
  logic signed [CMP_W-1:0] thr, alt_ext;
  logic                    too_low, over;
  logic [CNT_W-1:0]        lc_inc;

  assign m100 = (MUL_W'(cfg.min_altitude_m) << 6) + (MUL_W'(cfg.min_altitude_m) << 5)
              + (MUL_W'(cfg.min_altitude_m) << 2);
  assign thr     = $signed(CMP_W'(m100));
  assign alt_ext = CMP_W'(altitude_cm);
  assign too_low = (loss_count == '0) && (cfg.min_altitude_m != '0) && (alt_ext < thr);
  assign over    = angle_error_cdeg > cfg.angle_limit_cdeg;
  assign lc_inc  = (loss_count < cfg.trigger_ticks) ? loss_count + CNT_W'(1) : loss_count;

  always_comb begin
    loss_count_next    = loss_count;
    baro_start_cm_next = baro_start_cm;
    res                = '0;
    if (flags.chute_enabled) begin
      res.flying = !flags.landed;
      if (flags.standby) begin
        // hold everything
      end else if (!flags.armed) begin
        loss_count_next = '0;
      end else if (flags.release_started) begin
        res.disarm_request = 1'b1;
      end else if (flags.acro_or_flip || flags.landed || !cfg.crash_check_enable) begin
        loss_count_next = '0;
      end else if (too_low) begin
        // not high enough to start counting
      end else if (!over) begin
        if (loss_count != '0) loss_count_next = loss_count - CNT_W'(1);
      end else begin
        loss_count_next = lc_inc;
        if (lc_inc == CNT_W'(1)) begin
          baro_start_cm_next = baro_altitude_cm;
        end else if (baro_altitude_cm >= baro_start_cm) begin
          loss_count_next = '0;
        end else if (lc_inc >= cfg.trigger_ticks) begin
          loss_count_next    = '0;
          res.fire_release   = 1'b1;
          res.disarm_request = 1'b1;
        end
      end
    end
    res.loss_count = loss_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_count    <= '0;
      baro_start_cm <= '0;
    end else if (update) begin
      loss_count    <= loss_count_next;
      baro_start_cm <= baro_start_cm_next;
    end
  end

endmodule
`default_nettype wire

[src/loss_of_control_chute_trigger.sv]
// Loss-of-control parachute trigger, top level.
// Depends on lcct_pkg, lcct_cfg and lcct_step.
//
// Usage:
//   One flight-state snapshot per control-loop tick enters on the input
//   channel (in_valid / in_stall); one result item per snapshot leaves on
//   the output channel (out_valid / out_stall). An item moves at a rising
//   edge where valid is high and stall is low.
//   The snapshot is held in an input register, then the counter update and
//   the result are computed and captured in the output register together.
//   A new item is taken every cycle while the receiver does not stall; the
//   rate is set by the single counter update per item in the step logic.
//   When the receiver stalls, the result holds in the output register and
//   the next snapshot waits in the input register; in_stall rises only when
//   both are full.
//   Settings are to be written through the APB-style port (4 registers at byte
//   addresses 0, 4, 8, 12) while no item is in flight; the block does not enforce it.
//   Synchronous reset empties both registers, clears the loss counter and
//   baro latch and loads the default settings.
`default_nettype none
module loss_of_control_chute_trigger #(
  parameter int ALT_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lcct_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [lcct_pkg::PDATA_W-1:0]  pwdata,
  output logic      [lcct_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          chute_enabled,
  input  wire logic                          standby,
  input  wire logic                          armed,
  input  wire logic                          release_started,
  input  wire logic                          acro_or_flip,
  input  wire logic                          landed,
  input  wire logic signed [ALT_BITS-1:0]    altitude_cm,
  input  wire logic [lcct_pkg::ANG_W-1:0]    angle_error_cdeg,
  input  wire logic signed [ALT_BITS-1:0]    baro_altitude_cm,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               fire_release,
  output logic                               disarm_request,
  output logic                               flying,
  output logic [lcct_pkg::CNT_W-1:0]         loss_count_out
);
  import lcct_pkg::*;

  cfg_t cfg;
  res_t res;

  logic                       s1_valid;
  flags_t                     s1_flags;
  logic signed [ALT_BITS-1:0] s1_alt, s1_baro;
  logic [ANG_W-1:0]           s1_err;
  logic                       advance, in_take;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  lcct_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg(cfg)
  );

  lcct_step #(.ALT_BITS(ALT_BITS)) u_step (
    .clk, .rst,
    .update(advance),
    .cfg(cfg),
    .flags(s1_flags),
    .altitude_cm(s1_alt),
    .angle_error_cdeg(s1_err),
    .baro_altitude_cm(s1_baro),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_flags <= '{chute_enabled: chute_enabled, standby: standby, armed: armed,
                    release_started: release_started, acro_or_flip: acro_or_flip,
                    landed: landed};
      s1_alt   <= altitude_cm;
      s1_err   <= angle_error_cdeg;
      s1_baro  <= baro_altitude_cm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fire_release   <= res.fire_release;
      disarm_request <= res.disarm_request;
      flying         <= res.flying;
      loss_count_out <= res.loss_count;
    end
  end

  // a release always comes with a disarm, and clears the counter
  a_fire_disarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && fire_release |-> disarm_request && (loss_count_out == '0))
    else $error("release without disarm or with live count");

  // a held snapshot reaches the output register when it is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("held item did not advance");

  // input is never refused while the input register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("stall with empty input register");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

[tb/lcct_tick_checker.sv]
// Result checker for the loss-of-control chute trigger: mirrors the settings
// from the register port and predicts one result per accepted tick.
// Depends on lcct_pkg; instantiated beside the block by the test top.
`default_nettype none
module lcct_tick_checker #(
  parameter int ALT_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic                          pready,
  input  wire logic [lcct_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [lcct_pkg::PDATA_W-1:0]  pwdata,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          chute_enabled,
  input  wire logic                          standby,
  input  wire logic                          armed,
  input  wire logic                          release_started,
  input  wire logic                          acro_or_flip,
  input  wire logic                          landed,
  input  wire logic signed [ALT_BITS-1:0]    altitude_cm,
  input  wire logic [lcct_pkg::ANG_W-1:0]    angle_error_cdeg,
  input  wire logic signed [ALT_BITS-1:0]    baro_altitude_cm,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          fire_release,
  input  wire logic                          disarm_request,
  input  wire logic                          flying,
  input  wire logic [lcct_pkg::CNT_W-1:0]    loss_count_out,
  output int unsigned                        errors,
  output int unsigned                        ticks_checked,
  output int unsigned                        releases_seen,
  output int unsigned                        waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcct_pkg::*;

  cfg_t                       cfg;
  logic [CNT_W-1:0]           loss_cnt;
  logic signed [ALT_BITS-1:0] baro_latch;
  res_t                       expected_ticks[$];

  // Advance the trigger state by one tick and return the result it gives.
  function automatic res_t advance_tick(input flags_t f,
                                        input logic signed [ALT_BITS-1:0] alt,
                                        input logic [ANG_W-1:0] err,
                                        input logic signed [ALT_BITS-1:0] baro);
    res_t    r;
    longint  alt_l;
    longint  floor_l;
    r = '0;
    alt_l = longint'(alt);
    floor_l = longint'(cfg.min_altitude_m) * 100;
    if (f.chute_enabled) begin
      r.flying = ~f.landed;
      if (f.standby) begin
        // hold everything
      end else if (!f.armed) begin
        loss_cnt = '0;
      end else if (f.release_started) begin
        r.disarm_request = 1'b1;
      end else if (f.acro_or_flip || f.landed || !cfg.crash_check_enable) begin
        loss_cnt = '0;
      end else if (loss_cnt == '0 && cfg.min_altitude_m != '0 && alt_l < floor_l) begin
        // too low to start counting
      end else if (err <= cfg.angle_limit_cdeg) begin
        if (loss_cnt != '0) loss_cnt = loss_cnt - CNT_W'(1);
      end else begin
        if (loss_cnt < cfg.trigger_ticks) loss_cnt = loss_cnt + CNT_W'(1);
        if (loss_cnt == CNT_W'(1)) begin
          baro_latch = baro;
        end else if (baro >= baro_latch) begin
          loss_cnt = '0;
        end else if (loss_cnt >= cfg.trigger_ticks) begin
          loss_cnt = '0;
          r.fire_release = 1'b1;
          r.disarm_request = 1'b1;
        end
      end
    end
    r.loss_count = loss_cnt;
    return r;
  endfunction

  task automatic log_failure(input string why, input res_t want, input res_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: want fire/disarm/flying/count %0b/%0b/%0b/%0d, got %0b/%0b/%0b/%0d",
               $time, why, want.fire_release, want.disarm_request, want.flying,
               want.loss_count, got.fire_release, got.disarm_request, got.flying,
               got.loss_count);
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      cfg.crash_check_enable = RST_CRASH_EN;
      cfg.min_altitude_m = RST_MIN_ALT;
      cfg.trigger_ticks = RST_TRIG;
      cfg.angle_limit_cdeg = RST_ANG_LIMIT;
      loss_cnt = '0;
      baro_latch = '0;
      expected_ticks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CRASH_EN:  cfg.crash_check_enable = pwdata[0];
          REG_MIN_ALT:   cfg.min_altitude_m = pwdata[MALT_W-1:0];
          REG_TRIG:      cfg.trigger_ticks = pwdata[CNT_W-1:0];
          REG_ANG_LIMIT: cfg.angle_limit_cdeg = pwdata[ANG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {fire_release, disarm_request, flying, loss_count_out};
        if (expected_ticks.size() == 0) begin
          log_failure("result with nothing expected", '0, got);
        end else begin
          want = expected_ticks.pop_front();
          if (got.fire_release !== want.fire_release ||
              got.disarm_request !== want.disarm_request ||
              got.flying !== want.flying ||
              got.loss_count !== want.loss_count)
            log_failure("result mismatch", want, got);
          ticks_checked++;
          if (want.fire_release) releases_seen++;
        end
      end
      if (in_valid && !in_stall)
        expected_ticks.push_back(advance_tick({chute_enabled, standby, armed,
                                               release_started, acro_or_flip, landed},
                                              altitude_cm, angle_error_cdeg,
                                              baro_altitude_cm));
    end
    waiting <= expected_ticks.size();
  end

endmodule
`default_nettype wire

[tb/loss_of_control_chute_trigger_test.sv]
// Test top for the loss-of-control chute trigger: clock, reset, register
// writes and tick stimulus under several idling patterns; gives the verdict.
// Depends on lcct_pkg, loss_of_control_chute_trigger and lcct_tick_checker.
`default_nettype none
module loss_of_control_chute_trigger_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lcct_pkg::*;

  localparam int ALT_BITS = 24;
  localparam int ALT_MAX = 2 ** (ALT_BITS - 1) - 1;
  localparam int ALT_MIN = -(2 ** (ALT_BITS - 1));
  localparam int ERR_MAX = 2 ** ANG_W - 1;
  localparam int HOLD_CYCLES = 100;
  localparam longint LIMIT = 400000;
  localparam int NSET = 8;
  // flag order: enabled, standby, armed, release started, acro/flip, landed
  localparam logic [5:0] CRUISE = 6'b101000;

  typedef struct packed {
    flags_t                     f;
    logic signed [ALT_BITS-1:0] alt;
    logic [ANG_W-1:0]           err;
    logic signed [ALT_BITS-1:0] baro;
  } tick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic chute_enabled = 1'b0;
  logic standby = 1'b0;
  logic armed = 1'b0;
  logic release_started = 1'b0;
  logic acro_or_flip = 1'b0;
  logic landed = 1'b0;
  logic signed [ALT_BITS-1:0] altitude_cm = '0;
  logic [ANG_W-1:0] angle_error_cdeg = '0;
  logic signed [ALT_BITS-1:0] baro_altitude_cm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic fire_release;
  logic disarm_request;
  logic flying;
  logic [CNT_W-1:0] loss_count_out;

  int unsigned fail_count;
  int unsigned ticks_checked;
  int unsigned releases_seen;
  int unsigned waiting_ticks;

  int unsigned set_crash[NSET] = '{1, 1, 1, 0, 1, 1, 1, 1};
  int unsigned set_min[NSET]   = '{10, 0, 32000, 10, 1, 5, 100, 20};
  int unsigned set_trig[NSET]  = '{3, 5, 8, 4, 65535, 0, 12, 2};
  int unsigned set_ang[NSET]   = '{3000, 0, 18000, 3000, 100, 2000, 4500, 1500};

  int unsigned cur_min, cur_trig, cur_ang;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  longint unsigned cycles = 0;

  loss_of_control_chute_trigger #(.ALT_BITS(ALT_BITS)) dut (.*);

  lcct_tick_checker #(.ALT_BITS(ALT_BITS)) watch (
    .*,
    .errors(fail_count),
    .ticks_checked(ticks_checked),
    .releases_seen(releases_seen),
    .waiting(waiting_ticks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("loss_of_control_chute_trigger_test: done, errors");
      $finish;
    end
  end

  function automatic tick_t snap(input logic [5:0] fl, input int alt, input int err,
                                 input int baro);
    tick_t s;
    s.f = flags_t'(fl);
    s.alt = ALT_BITS'(alt);
    s.err = ANG_W'(err);
    s.baro = ALT_BITS'(baro);
    return s;
  endfunction

  function automatic tick_t noise_tick();
    tick_t s;
    s.f = flags_t'(6'($urandom));
    if ($urandom_range(3) != 0) s.f.chute_enabled = 1'b1;
    if ($urandom_range(3) != 0) s.f.armed = 1'b1;
    s.alt = ALT_BITS'($urandom);
    s.err = ANG_W'($urandom);
    s.baro = ALT_BITS'($urandom);
    return s;
  endfunction

  task automatic send_tick(input tick_t s);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {chute_enabled, standby, armed, release_started, acro_or_flip, landed} <= s.f;
    altitude_cm <= s.alt;
    angle_error_cdeg <= s.err;
    baro_altitude_cm <= s.baro;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // A run of flying ticks with the error mostly over the limit and baro
  // mostly falling, so the counter climbs towards a release.
  task automatic loss_run();
    tick_t s;
    int unsigned len, floor_cm, k;
    int b;
    len = $urandom_range(2, (cur_trig > 40 ? 40 : cur_trig) + 4);
    floor_cm = cur_min * 100;
    if ($urandom_range(9) == 0) b = ALT_MAX;
    else b = int'($urandom_range(6000000)) - 3000000;
    for (k = 0; k < len; k++) begin
      s.f = flags_t'(CRUISE);
      if ($urandom_range(39) == 0) s.f[$urandom_range(5)] = ~s.f[$urandom_range(5)];
      s.alt = ALT_BITS'($urandom_range(floor_cm, ALT_MAX));
      if ($urandom_range(7) == 0) s.err = ANG_W'($urandom_range(0, cur_ang));
      else s.err = ANG_W'($urandom_range(cur_ang + 1, ERR_MAX));
      b = b - int'($urandom_range(1, 400));
      if ($urandom_range(29) == 0) b = b + int'($urandom_range(0, 800));
      s.baro = ALT_BITS'(b);
      send_tick(s);
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(3) != 0) loss_run();
      else repeat ($urandom_range(1, 3)) send_tick(noise_tick());
    end
  endtask

  // drop valid and let every expected result arrive, plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_ticks != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Directed ticks, for minimum altitude 10 m, trigger 3 and limit 3000.
  task automatic directed_ticks();
    send_tick(snap(6'b011111, ALT_MAX, ERR_MAX, ALT_MIN));  // disabled
    send_tick(snap(6'b111000, 5000, 5000, 0));              // standby, flying
    send_tick(snap(6'b110001, 5000, 5000, 0));              // standby, landed
    send_tick(snap(6'b100000, 5000, 5000, 0));              // disarmed
    send_tick(snap(CRUISE, 1000, 3001, 5000));              // floor exactly met
    send_tick(snap(CRUISE, 1000, 3000, 5000));              // error at the limit
    send_tick(snap(CRUISE, 999, ERR_MAX, 0));               // too low
    send_tick(snap(CRUISE, ALT_MIN, ERR_MAX, 0));
    send_tick(snap(CRUISE, ALT_MAX, ERR_MAX, 0));
    send_tick(snap(CRUISE, 0, 3001, -1));
    send_tick(snap(CRUISE, 0, 3001, -2));                   // release
    send_tick(snap(CRUISE, 2000, 3001, 100));
    send_tick(snap(CRUISE, 2000, 3001, 100));               // baro not falling
    send_tick(snap(CRUISE, 2000, 3001, 50));
    send_tick(snap(6'b101100, 2000, 3001, 40));             // release under way
    send_tick(snap(6'b101010, 2000, 3001, 40));             // acro or flip
    send_tick(snap(CRUISE, 2000, 3001, 10));
    send_tick(snap(6'b101001, 2000, 3001, 10));             // landed
    send_tick(snap(CRUISE, 2000, 3001, 10));
    send_tick(snap(CRUISE, 2000, 0, 10));
    send_tick(snap(CRUISE, 2000, 0, 10));
    send_tick(snap(CRUISE, 5000, 18000, ALT_MAX));
    send_tick(snap(CRUISE, 5000, 18000, ALT_MIN));
    send_tick(snap(CRUISE, 5000, 18000, ALT_MIN));
  endtask

  initial begin
    int p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    cur_min = 32'(RST_MIN_ALT);
    cur_trig = 32'(RST_TRIG);
    cur_ang = 32'(RST_ANG_LIMIT);
    run_random(100);
    for (p = 1; p <= NSET; p++) begin
      settle();
      write_reg(REG_CRASH_EN, set_crash[p-1]);
      write_reg(REG_MIN_ALT, set_min[p-1]);
      write_reg(REG_TRIG, set_trig[p-1]);
      write_reg(REG_ANG_LIMIT, set_ang[p-1]);
      cur_min = set_min[p-1];
      cur_trig = set_trig[p-1];
      cur_ang = set_ang[p-1];
      case (p % 4)
        0: begin gap_pct = 0; stall_pct <= 0; end
        1: begin gap_pct = 65; stall_pct <= 0; end
        2: begin gap_pct = 0; stall_pct <= 65; end
        default: begin gap_pct = 26; stall_pct <= 26; end
      endcase
      // keep offering ticks through a long hold-off so the input backs up
      if (p == 2 || p == 6) holds_asked <= holds_asked + 1;
      if (p == 1) directed_ticks();
      run_random(p == 1 ? 180 : 200);
    end
    settle();
    $display("sent %0d ticks over %0d register settings and four idling patterns",
             items_sent, NSET + 1);
    $display("checked %0d results, %0d of them parachute releases", ticks_checked,
             releases_seen);
    if (fail_count == 0) begin
      $display("loss_of_control_chute_trigger_test: done, clean");
    end else begin
      $display("loss_of_control_chute_trigger_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
